// ===== hdl/rwmh_pkg.sv =====
// ----------------------------------------------------------------------------
// rwmh_pkg
// Shared types and constants for the rain wiper mode hysteresis unit.
// ----------------------------------------------------------------------------
package rwmh_pkg;

    localparam int unsigned LEVEL_W  = 7;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned DIAG_W   = 2;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned IDX_W    = 3;

    // Wiper modes
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd3;

    // Sensor read status
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STALE   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd3;

    // Diagnostic events
    localparam logic [DIAG_W-1:0] DIAG_NONE    = 2'd0;
    localparam logic [DIAG_W-1:0] DIAG_INVALID = 2'd1;
    localparam logic [DIAG_W-1:0] DIAG_STALE   = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [IDX_W-1:0] REG_INT_ON    = 3'd0;
    localparam logic [IDX_W-1:0] REG_INT_OFF   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOW_ON    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOW_OFF   = 3'd3;
    localparam logic [IDX_W-1:0] REG_HIGH_ON   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HIGH_OFF  = 3'd5;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 3'd6;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_INT_ON   = 7'd20;
    localparam logic [LEVEL_W-1:0] RST_INT_OFF  = 7'd15;
    localparam logic [LEVEL_W-1:0] RST_LOW_ON   = 7'd40;
    localparam logic [LEVEL_W-1:0] RST_LOW_OFF  = 7'd35;
    localparam logic [LEVEL_W-1:0] RST_HIGH_ON  = 7'd70;
    localparam logic [LEVEL_W-1:0] RST_HIGH_OFF = 7'd60;
    localparam logic [COUNT_W-1:0] RST_DEBOUNCE = 4'd2;

    localparam logic [LEVEL_W-1:0] RAIN_MAX = 7'd100;

    typedef struct packed {
        logic [LEVEL_W-1:0] int_on;
        logic [LEVEL_W-1:0] int_off;
        logic [LEVEL_W-1:0] low_on;
        logic [LEVEL_W-1:0] low_off;
        logic [LEVEL_W-1:0] high_on;
        logic [LEVEL_W-1:0] high_off;
        logic [COUNT_W-1:0] debounce;
    } t_cfg;

endpackage

// ===== hdl/rwmh_regs.sv =====
// ----------------------------------------------------------------------------
// rwmh_regs
// APB-style configuration registers: thresholds and debounce count.
// ----------------------------------------------------------------------------
module rwmh_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rwmh_pkg::ADDR_W-1:0]  paddr,
    input  logic [rwmh_pkg::DATA_W-1:0]  pwdata,
    output logic [rwmh_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output rwmh_pkg::t_cfg               o_cfg
);

    rwmh_pkg::t_cfg                  r_cfg;
    logic                            w_wr;
    logic [rwmh_pkg::IDX_W-1:0]      w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[rwmh_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.int_on   <= rwmh_pkg::RST_INT_ON;
            r_cfg.int_off  <= rwmh_pkg::RST_INT_OFF;
            r_cfg.low_on   <= rwmh_pkg::RST_LOW_ON;
            r_cfg.low_off  <= rwmh_pkg::RST_LOW_OFF;
            r_cfg.high_on  <= rwmh_pkg::RST_HIGH_ON;
            r_cfg.high_off <= rwmh_pkg::RST_HIGH_OFF;
            r_cfg.debounce <= rwmh_pkg::RST_DEBOUNCE;
        end else if (w_wr) begin
            case (w_idx)
                rwmh_pkg::REG_INT_ON:   r_cfg.int_on   <= pwdata[rwmh_pkg::LEVEL_W-1:0];
                rwmh_pkg::REG_INT_OFF:  r_cfg.int_off  <= pwdata[rwmh_pkg::LEVEL_W-1:0];
                rwmh_pkg::REG_LOW_ON:   r_cfg.low_on   <= pwdata[rwmh_pkg::LEVEL_W-1:0];
                rwmh_pkg::REG_LOW_OFF:  r_cfg.low_off  <= pwdata[rwmh_pkg::LEVEL_W-1:0];
                rwmh_pkg::REG_HIGH_ON:  r_cfg.high_on  <= pwdata[rwmh_pkg::LEVEL_W-1:0];
                rwmh_pkg::REG_HIGH_OFF: r_cfg.high_off <= pwdata[rwmh_pkg::LEVEL_W-1:0];
                rwmh_pkg::REG_DEBOUNCE: r_cfg.debounce <= pwdata[rwmh_pkg::COUNT_W-1:0];
                default: ;  // drop writes outside the map
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            rwmh_pkg::REG_INT_ON:   prdata[rwmh_pkg::LEVEL_W-1:0] = r_cfg.int_on;
            rwmh_pkg::REG_INT_OFF:  prdata[rwmh_pkg::LEVEL_W-1:0] = r_cfg.int_off;
            rwmh_pkg::REG_LOW_ON:   prdata[rwmh_pkg::LEVEL_W-1:0] = r_cfg.low_on;
            rwmh_pkg::REG_LOW_OFF:  prdata[rwmh_pkg::LEVEL_W-1:0] = r_cfg.low_off;
            rwmh_pkg::REG_HIGH_ON:  prdata[rwmh_pkg::LEVEL_W-1:0] = r_cfg.high_on;
            rwmh_pkg::REG_HIGH_OFF: prdata[rwmh_pkg::LEVEL_W-1:0] = r_cfg.high_off;
            rwmh_pkg::REG_DEBOUNCE: prdata[rwmh_pkg::COUNT_W-1:0] = r_cfg.debounce;
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/rwmh_core.sv =====
// ----------------------------------------------------------------------------
// rwmh_core
// Hysteresis proposal, debounce counter and committed mode state.
// ----------------------------------------------------------------------------
module rwmh_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [rwmh_pkg::LEVEL_W-1:0]   i_rain_level,
    input  logic [rwmh_pkg::STATUS_W-1:0]  i_read_status,
    input  rwmh_pkg::t_cfg                 i_cfg,
    output logic [rwmh_pkg::MODE_W-1:0]    o_wiper_mode,
    output logic [rwmh_pkg::DIAG_W-1:0]    o_diag_event
);

    logic [rwmh_pkg::MODE_W-1:0]   r_committed;
    logic [rwmh_pkg::MODE_W-1:0]   r_candidate;
    logic [rwmh_pkg::COUNT_W-1:0]  r_count;
    logic [rwmh_pkg::MODE_W-1:0]   n_committed;
    logic [rwmh_pkg::MODE_W-1:0]   n_candidate;
    logic [rwmh_pkg::COUNT_W-1:0]  n_count;
    logic [rwmh_pkg::LEVEL_W-1:0]  w_rain;
    logic [rwmh_pkg::MODE_W-1:0]   w_proposal;
    logic [rwmh_pkg::DIAG_W-1:0]   w_event;

    assign w_rain = (i_rain_level > rwmh_pkg::RAIN_MAX) ? rwmh_pkg::RAIN_MAX : i_rain_level;

    always_comb begin
        case (r_committed)
            rwmh_pkg::MODE_OFF: begin
                w_proposal = (w_rain >= i_cfg.int_on) ? rwmh_pkg::MODE_INT : rwmh_pkg::MODE_OFF;
            end
            rwmh_pkg::MODE_INT: begin
                if (w_rain < i_cfg.int_off)
                    w_proposal = rwmh_pkg::MODE_OFF;
                else if (w_rain >= i_cfg.low_on)
                    w_proposal = rwmh_pkg::MODE_LOW;
                else
                    w_proposal = rwmh_pkg::MODE_INT;
            end
            rwmh_pkg::MODE_LOW: begin
                if (w_rain < i_cfg.low_off)
                    w_proposal = rwmh_pkg::MODE_INT;
                else if (w_rain >= i_cfg.high_on)
                    w_proposal = rwmh_pkg::MODE_HIGH;
                else
                    w_proposal = rwmh_pkg::MODE_LOW;
            end
            default: begin
                w_proposal = (w_rain < i_cfg.high_off) ? rwmh_pkg::MODE_LOW : rwmh_pkg::MODE_HIGH;
            end
        endcase
    end

    always_comb begin
        n_committed = r_committed;
        n_candidate = r_candidate;
        n_count     = r_count;
        w_event     = rwmh_pkg::DIAG_NONE;
        if (i_read_status != rwmh_pkg::STATUS_OK) begin
            // failed read: force everything back to off
            n_committed = rwmh_pkg::MODE_OFF;
            n_candidate = rwmh_pkg::MODE_OFF;
            n_count     = '0;
            case (i_read_status)
                rwmh_pkg::STATUS_NO_DATA: w_event = rwmh_pkg::DIAG_INVALID;
                rwmh_pkg::STATUS_STALE:   w_event = rwmh_pkg::DIAG_STALE;
                default:                  w_event = rwmh_pkg::DIAG_NONE;
            endcase
        end else if (w_proposal == r_candidate) begin
            if (r_count < i_cfg.debounce)
                n_count = r_count + 1'b1;
            if (n_count >= i_cfg.debounce)
                n_committed = w_proposal;
        end else begin
            n_candidate = w_proposal;
            n_count     = 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= rwmh_pkg::MODE_OFF;
            r_candidate <= rwmh_pkg::MODE_OFF;
            r_count     <= '0;
        end else if (i_advance) begin
            r_committed <= n_committed;
            r_candidate <= n_candidate;
            r_count     <= n_count;
        end
    end

    assign o_wiper_mode = n_committed;
    assign o_diag_event = w_event;

endmodule

// ===== hdl/rain_wiper_mode_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// rain_wiper_mode_hysteresis_unit
// Rain sensor wiper mode selector: four-level hysteresis with debounce.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-----------------------------
//  reading   | in        | i_in_valid / o_in_ready   | i_rain_level, i_read_status
//  mode      | out       | o_out_valid / i_out_ready | o_wiper_mode, o_diag_event
//  config    | in        | psel, penable, pwrite     | paddr, pwdata, prdata
//
//  One reading per cycle sustained while the mode output is not stalled.
//  The input register feeds the hysteresis/debounce logic into the result register.
//  Reset is synchronous and active low; state and thresholds return to defaults.
//  A stalled result holds in the output register while one more reading is taken.
// ----------------------------------------------------------------------------
module rain_wiper_mode_hysteresis_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rwmh_pkg::LEVEL_W-1:0]   i_rain_level,
    input  logic [rwmh_pkg::STATUS_W-1:0]  i_read_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rwmh_pkg::MODE_W-1:0]    o_wiper_mode,
    output logic [rwmh_pkg::DIAG_W-1:0]    o_diag_event,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rwmh_pkg::ADDR_W-1:0]    paddr,
    input  logic [rwmh_pkg::DATA_W-1:0]    pwdata,
    output logic [rwmh_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    rwmh_pkg::t_cfg                  w_cfg;
    logic                            r_in_valid;
    logic [rwmh_pkg::LEVEL_W-1:0]    r_rain;
    logic [rwmh_pkg::STATUS_W-1:0]   r_status;
    logic                            r_out_valid;
    logic [rwmh_pkg::MODE_W-1:0]     r_mode;
    logic [rwmh_pkg::DIAG_W-1:0]     r_event;
    logic [rwmh_pkg::MODE_W-1:0]     w_mode;
    logic [rwmh_pkg::DIAG_W-1:0]     w_event;
    logic                            w_out_free;
    logic                            w_adv;
    logic                            w_in_acc;

    rwmh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rwmh_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_adv),
        .i_rain_level  (r_rain),
        .i_read_status (r_status),
        .i_cfg         (w_cfg),
        .o_wiper_mode  (w_mode),
        .o_diag_event  (w_event)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready)
                r_in_valid <= i_in_valid;
            if (w_out_free)
                r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rain   <= i_rain_level;
            r_status <= i_read_status;
        end
        if (!i_rst_n) begin
            r_mode  <= rwmh_pkg::MODE_OFF;
            r_event <= rwmh_pkg::DIAG_NONE;
        end else if (w_adv) begin
            r_mode  <= w_mode;
            r_event <= w_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_wiper_mode = r_mode;
    assign o_diag_event = r_event;

`ifndef SYNTHESIS
    // a failed read always reports off
    a_fail_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_status != rwmh_pkg::STATUS_OK) |=> (o_wiper_mode == rwmh_pkg::MODE_OFF))
        else $error("failed read did not force wiper off");

    // a good read never raises a diagnostic
    a_ok_no_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_status == rwmh_pkg::STATUS_OK) |=> (o_diag_event == rwmh_pkg::DIAG_NONE))
        else $error("diagnostic raised on a good read");

    // stale read maps to the stale event
    a_stale_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_status == rwmh_pkg::STATUS_STALE) |=> (o_diag_event == rwmh_pkg::DIAG_STALE))
        else $error("stale read did not report stale event");

    // result register only changes when an item moves into it
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> ($stable(r_mode) && $stable(r_event)))
        else $error("result register changed without an advancing transaction");
`endif

endmodule
